// ----- src/dsg_pkg.sv -----
// Shared definitions for the decaying sine generator: widths, register indexes,
// multiplier operand selects and the microcode program of the sequencer.
// No dependencies.
package dsg_pkg;

    // Default parameter values for the top level.
    localparam int DSG_PHASE_BITS      = 32;
    localparam int DSG_SINE_TABLE_BITS = 10;
    localparam int DSG_ENV_FRAC_BITS   = 24;
    localparam int DSG_COUNT_BITS      = 24;

    // Fixed widths of the register file and of the sample path.
    localparam int SINE_W       = 15;
    localparam int STEP_REG_W   = 32;
    localparam int AMP_REG_W    = 15;
    localparam int COUNT_REG_W  = 24;
    localparam int SAMPLE_W     = 16;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_AMPLITUDE    = 2'd1,
        CFG_DECAY_RATIO  = 2'd2,
        CFG_SAMPLE_COUNT = 2'd3
    } t_cfg_idx;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_NONE      = 2'd0,
        MUL_AMP_SINE  = 2'd1,
        MUL_PROD_ENV  = 2'd2,
        MUL_ENV_RATIO = 2'd3
    } t_mul_op;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_ACCEPT   = 3'd0;
    localparam t_step STEP_SCALE    = 3'd1;
    localparam t_step STEP_ENVELOPE = 3'd2;
    localparam t_step STEP_DIVIDE   = 3'd3;
    localparam t_step STEP_EMIT     = 3'd4;

    // One control word per step.
    typedef struct packed {
        logic    accept;        // take an input transfer, wait here until one comes
        logic    skip_if_done;  // return to accept when the tone is finished
        t_mul_op mul_op;        // multiplier operands, product registered
        logic    take_mag;      // register the scaled magnitude
        logic    emit;          // load the result register, wait while it is full
        t_step   next_step;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{accept: 1'b0, skip_if_done: 1'b0, mul_op: MUL_NONE,
              take_mag: 1'b0, emit: 1'b0, next_step: STEP_ACCEPT};
        case (step)
            STEP_ACCEPT: begin
                w.accept    = 1'b1;
                w.next_step = STEP_SCALE;
            end
            STEP_SCALE: begin
                w.skip_if_done = 1'b1;
                w.mul_op       = MUL_AMP_SINE;
                w.next_step    = STEP_ENVELOPE;
            end
            STEP_ENVELOPE: begin
                w.mul_op    = MUL_PROD_ENV;
                w.next_step = STEP_DIVIDE;
            end
            STEP_DIVIDE: begin
                w.mul_op    = MUL_ENV_RATIO;
                w.take_mag  = 1'b1;
                w.next_step = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit      = 1'b1;
                w.next_step = STEP_ACCEPT;
            end
            default: begin
                w.next_step = STEP_ACCEPT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/dsg_sine_rom.sv -----
// Quarter-wave sine magnitude table with a registered read port.
// Depends on dsg_pkg; the table is built at elaboration from an odd polynomial.
module dsg_sine_rom
    import dsg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = DSG_SINE_TABLE_BITS
) (
    input  logic                       i_clk,
    input  logic [SINE_TABLE_BITS-2:0] i_addr,
    output logic [SINE_W-1:0]          o_data
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

    // Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam longint unsigned SC1 = 64'd1686629713;
    localparam longint unsigned SC3 = 64'd693598668;
    localparam longint unsigned SC5 = 64'd85569306;
    localparam longint unsigned SC7 = 64'd5026995;
    localparam longint unsigned SC9 = 64'd172272;

    // Magnitude of quarter-wave entry r in Q1.15, rounded half up and clamped.
    function automatic logic [SINE_W-1:0] sine_entry(input int r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned y;
        longint unsigned v;
        x  = longint'(r) << (30 - (SINE_TABLE_BITS - 2));
        x2 = (x * x) >> 30;
        s  = SC9;
        s  = SC7 - ((x2 * s) >> 30);
        s  = SC5 - ((x2 * s) >> 30);
        s  = SC3 - ((x2 * s) >> 30);
        s  = SC1 - ((x2 * s) >> 30);
        y  = (x * s) >> 30;
        v  = (y + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

    logic [SINE_W-1:0] rom_tab [0:QUARTER];

    for (genvar g = 0; g <= QUARTER; g = g + 1) begin : g_tab
        assign rom_tab[g] = sine_entry(g);
    end

    logic [SINE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= rom_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- src/decaying_sine_generator.sv -----
// Decaying sine generator. Each input transfer asks for one sample; a restart
// flag in the transfer first clears phase, envelope, frame and peak. While
// fewer than sample_count samples have been produced, the block answers with
// one output transfer carrying the sample, its frame, a last flag and the
// running peak magnitude with the frame where it first occurred; once the tone
// is finished a request produces no output transfer. A request runs through
// five steps: one to accept it and read the sine table, three on the single
// shared multiplier (amplitude times sine, times envelope, then envelope
// times decay ratio) and one to load the result register. A finished tone
// or a restart with a sample count of zero returns to accept straight from
// the scale step. A finished sample waits in the output register,
// so the next request is taken while it is still stalled; only its own emit
// step waits for the register to drain. Configuration registers may be
// written whenever the block is idle.
module decaying_sine_generator
    import dsg_pkg::*;
#(
    parameter int PHASE_BITS      = DSG_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DSG_SINE_TABLE_BITS,
    parameter int ENV_FRAC_BITS   = DSG_ENV_FRAC_BITS,
    parameter int COUNT_BITS      = DSG_COUNT_BITS,
    localparam int ENV_W          = ENV_FRAC_BITS + 1,
    localparam int CFG_W          = (ENV_W > STEP_REG_W) ? ENV_W : STEP_REG_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,

    // Request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_restart,

    // Sample channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_sample,
    output logic [COUNT_BITS-1:0] o_frame,
    output logic                  o_is_last,
    output logic [SAMPLE_W-1:0]   o_peak_value,
    output logic [COUNT_BITS-1:0] o_peak_frame
);

    // Amplitude times sine magnitude sets the width of the multiplier's first operand.
    localparam int MAG_W     = 2 * SINE_W;
    localparam int MUL_A_W   = (MAG_W > ENV_W) ? MAG_W : ENV_W;
    localparam int MUL_B_W   = ENV_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ROM_A_W   = SINE_TABLE_BITS - 1;

    localparam logic [ENV_W-1:0]   ENV_ONE     = {1'b1, {ENV_FRAC_BITS{1'b0}}};
    localparam logic [ROM_A_W-1:0] QUARTER_IDX = ROM_A_W'(1 << (SINE_TABLE_BITS - 2));

    // Configuration registers.
    logic [STEP_REG_W-1:0]  r_phase_step;
    logic [AMP_REG_W-1:0]   r_amplitude;
    logic [ENV_W-1:0]       r_decay_ratio;
    logic [COUNT_REG_W-1:0] r_sample_count;

    // Tone state.
    logic [PHASE_BITS-1:0]  r_phase;
    logic [ENV_W-1:0]       r_envelope;
    logic [COUNT_BITS-1:0]  r_frame;
    logic [SAMPLE_W-1:0]    r_peak_mag;
    logic [COUNT_BITS-1:0]  r_peak_frame;

    // Sequencer and datapath registers.
    t_step                  r_step;
    t_step                  n_step;
    logic                   r_neg;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_W-1:0]    r_mag;

    // Result register.
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_sample;
    logic [COUNT_BITS-1:0]  r_out_frame;
    logic                   r_is_last;
    logic [SAMPLE_W-1:0]    r_out_peak;
    logic [COUNT_BITS-1:0]  r_out_peak_frame;

    t_ctrl                  ctrl;
    logic                   in_fire;
    logic                   out_free;
    logic                   emit_fire;
    logic                   tone_done;
    logic [COUNT_BITS-1:0]  count;

    logic [PHASE_BITS-1:0]      read_phase;
    logic [SINE_TABLE_BITS-1:0] table_idx;
    logic [ROM_A_W-1:0]         rom_addr;
    logic [SINE_W-1:0]          sine_mag;

    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [ENV_W-1:0]       ratio;

    logic [MAG_W-1:0]       scaled;
    logic [SINE_W-1:0]      quot_lo;
    logic [SAMPLE_W-1:0]    div_rem;
    logic [SAMPLE_W-1:0]    div_quot;
    logic [SAMPLE_W-1:0]    mag_clamped;

    logic                   new_peak;
    logic [SAMPLE_W-1:0]    peak_next;
    logic [COUNT_BITS-1:0]  peak_frame_next;

    // ------------------------------------------------------------------
    // Sequencer: the step counter addresses the microcode table.
    // ------------------------------------------------------------------
    assign ctrl      = ucode(r_step);
    assign in_fire   = ctrl.accept && i_in_valid;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = ctrl.emit && out_free;
    assign count     = COUNT_BITS'(r_sample_count);
    assign tone_done = (r_frame >= count);

    always_comb begin
        n_step = ctrl.next_step;
        if (ctrl.accept && !i_in_valid) begin
            n_step = r_step;
        end else if (ctrl.skip_if_done && tone_done) begin
            n_step = STEP_ACCEPT;
        end else if (ctrl.emit && !out_free) begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_stall = !ctrl.accept;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_amplitude    <= AMP_REG_W'(FULL_SCALE);
            r_decay_ratio  <= ENV_ONE;
            r_sample_count <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata[STEP_REG_W-1:0];
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_wdata[AMP_REG_W-1:0];
                CFG_DECAY_RATIO:  r_decay_ratio  <= i_cfg_wdata[ENV_W-1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_wdata[COUNT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sine table read. The address is taken at the accept edge; a restart
    // clears the phase in the same edge, so the table sees phase zero.
    // The quarter-wave table is mirrored in odd quadrants, and the upper
    // half of the circle carries a negative sign.
    // ------------------------------------------------------------------
    assign read_phase = i_restart ? '0 : r_phase;
    assign table_idx  = read_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign rom_addr   = table_idx[SINE_TABLE_BITS-2]
                        ? (QUARTER_IDX - ROM_A_W'(table_idx[SINE_TABLE_BITS-3:0]))
                        : ROM_A_W'(table_idx[SINE_TABLE_BITS-3:0]);

    dsg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (sine_mag)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_neg <= table_idx[SINE_TABLE_BITS-1];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier. A decay ratio above one is treated as one.
    // ------------------------------------------------------------------
    assign ratio = (r_decay_ratio > ENV_ONE) ? ENV_ONE : r_decay_ratio;

    always_comb begin
        case (ctrl.mul_op)
            MUL_AMP_SINE: begin
                mul_a = MUL_A_W'(r_amplitude);
                mul_b = MUL_B_W'(sine_mag);
            end
            MUL_PROD_ENV: begin
                mul_a = MUL_A_W'(r_prod[MAG_W-1:0]);
                mul_b = r_envelope;
            end
            MUL_ENV_RATIO: begin
                mul_a = MUL_A_W'(r_envelope);
                mul_b = ratio;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_op != MUL_NONE) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // ------------------------------------------------------------------
    // Division by full scale. The scaled value never exceeds full scale
    // squared, so the quotient estimate from a 15-bit shift is short by at
    // most one and a single compare fixes it.
    // ------------------------------------------------------------------
    assign scaled   = r_prod[ENV_FRAC_BITS +: MAG_W];
    assign quot_lo  = scaled[MAG_W-1:SINE_W];
    assign div_rem  = SAMPLE_W'(scaled[SINE_W-1:0]) + SAMPLE_W'(quot_lo);
    assign div_quot = (div_rem >= FULL_SCALE) ? (SAMPLE_W'(quot_lo) + 1'b1)
                                              : SAMPLE_W'(quot_lo);
    assign mag_clamped = (div_quot > FULL_SCALE) ? FULL_SCALE : div_quot;

    always_ff @(posedge i_clk) begin
        if (ctrl.take_mag) begin
            r_mag <= mag_clamped;
        end
    end

    // ------------------------------------------------------------------
    // Tone state. A restart clears it at the accept edge; the emit step
    // advances phase, envelope and frame and follows the peak. An equal
    // magnitude later on leaves the peak frame where it was.
    // ------------------------------------------------------------------
    assign new_peak        = (r_mag > r_peak_mag);
    assign peak_next       = new_peak ? r_mag : r_peak_mag;
    assign peak_frame_next = new_peak ? r_frame : r_peak_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_envelope   <= ENV_ONE;
            r_frame      <= '0;
            r_peak_mag   <= '0;
            r_peak_frame <= '0;
        end else if (in_fire && i_restart) begin
            r_phase      <= '0;
            r_envelope   <= ENV_ONE;
            r_frame      <= '0;
            r_peak_mag   <= '0;
            r_peak_frame <= '0;
        end else if (emit_fire) begin
            r_phase      <= r_phase + PHASE_BITS'(r_phase_step);
            if (ratio != ENV_ONE) begin
                r_envelope <= r_prod[ENV_FRAC_BITS +: ENV_W];
            end
            r_frame      <= r_frame + 1'b1;
            r_peak_mag   <= peak_next;
            r_peak_frame <= peak_frame_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_sample         <= r_neg ? (SAMPLE_W'(0) - r_mag) : r_mag;
            r_out_frame      <= r_frame;
            r_is_last        <= (({1'b0, r_frame} + 1'b1) == {1'b0, count});
            r_out_peak       <= peak_next;
            r_out_peak_frame <= peak_frame_next;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample     = r_sample;
    assign o_frame      = r_out_frame;
    assign o_is_last    = r_is_last;
    assign o_peak_value = r_out_peak;
    assign o_peak_frame = r_out_peak_frame;

endmodule

// ----- tb/tb_decaying_sine_generator.sv -----
// Self-checking testbench for the decaying sine generator: directed script, then randomised
// tones under random idling on both channels, checked against an in-bench tone predictor.
// Depends on dsg_pkg and the decaying_sine_generator top level.
module tb_decaying_sine_generator;
    import dsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Widths and fixed-point constants of the default build.
    localparam int PHASE_W   = DSG_PHASE_BITS;
    localparam int TABLE_W   = DSG_SINE_TABLE_BITS;
    localparam int ENV_FRAC  = DSG_ENV_FRAC_BITS;
    localparam int FRAME_W   = DSG_COUNT_BITS;
    localparam int RATIO_W   = DSG_ENV_FRAC_BITS + 1;
    localparam int WDATA_W   = 32;
    localparam logic [RATIO_W-1:0] ENV_ONE = RATIO_W'(1) << ENV_FRAC;

    // Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598668;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026995;
    localparam logic [63:0] SC9 = 64'd172272;

    // Run control.
    localparam int          REQUEST_TARGET = 850;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          HOLD_AFTER     = 300;
    localparam int          MAX_REPORTS    = 30;
    localparam int unsigned CYCLE_LIMIT    = 600000;

    // One sample transfer as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic [FRAME_W-1:0]  frm;
        logic                last;
        logic [SAMPLE_W-1:0] pk;
        logic [FRAME_W-1:0]  pkf;
    } t_tone_sample;

    // One line of the directed script: either a register write or a request. Where
    // the outcome is obvious it is typed in, otherwise the predictor supplies it.
    typedef struct packed {
        bit                 wr;
        t_cfg_idx           idx;
        logic [WDATA_W-1:0] wdata;
        bit                 rs;
        bit                 typed;
        bit                 none;
        t_tone_sample       want;
    } t_script_row;

    localparam int SCRIPT_LEN = 36;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_idx = CFG_PHASE_STEP;
    logic [WDATA_W-1:0]    i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_restart = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   o_sample;
    logic [FRAME_W-1:0]    o_frame;
    logic                  o_is_last;
    logic [SAMPLE_W-1:0]   o_peak_value;
    logic [FRAME_W-1:0]    o_peak_frame;

    decaying_sine_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample     (o_sample),
        .o_frame      (o_frame),
        .o_is_last    (o_is_last),
        .o_peak_value (o_peak_value),
        .o_peak_frame (o_peak_frame)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor copy of the register file, at its reset values.
    logic [STEP_REG_W-1:0]  step_reg  = '0;
    logic [AMP_REG_W-1:0]   amp_reg   = 15'd32767;
    logic [RATIO_W-1:0]     ratio_reg = ENV_ONE;
    logic [COUNT_REG_W-1:0] count_reg = '0;

    // Predictor copy of the tone state.
    logic [PHASE_W-1:0]     ph_acc  = '0;
    logic [RATIO_W-1:0]     env_lvl = ENV_ONE;
    logic [FRAME_W-1:0]     frm_cnt = '0;
    logic [SAMPLE_W-1:0]    pk_mag  = '0;
    logic [FRAME_W-1:0]     pk_idx  = '0;

    // Samples predicted for accepted requests, oldest first.
    t_tone_sample expected_samples[$];

    int unsigned error_count     = 0;
    int unsigned samples_checked = 0;
    int unsigned requests_sent   = 0;
    int unsigned restarts_sent   = 0;
    int unsigned reg_writes      = 0;
    int unsigned cycle_count     = 0;

    t_script_row script [SCRIPT_LEN];

    // Table sine for index k: magnitude in Q1.15, with the sign returned apart. The
    // quarter wave comes from an odd ninth-order polynomial in Q30, mirrored in the
    // second and fourth quadrants and negated in the lower half.
    function automatic logic [SAMPLE_W-1:0] table_sine(input logic [TABLE_W-1:0] k,
                                                       output bit neg);
        logic [63:0] quarter, r, x, x2, s, y, v;
        logic [1:0]  quad;
        quarter = 64'd1 << (TABLE_W - 2);
        quad    = k[TABLE_W-1 -: 2];
        r       = 64'(k[TABLE_W-3:0]);
        if (quad[0])
            r = quarter - r;
        x  = r << (30 - (TABLE_W - 2));
        x2 = (x * x) >> 30;
        s  = SC9;
        s  = SC7 - ((x2 * s) >> 30);
        s  = SC5 - ((x2 * s) >> 30);
        s  = SC3 - ((x2 * s) >> 30);
        s  = SC1 - ((x2 * s) >> 30);
        y  = (x * s) >> 30;
        v  = (y + 64'd16384) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        neg = quad[1];
        return v[SAMPLE_W-1:0];
    endfunction

    // Advances the predicted tone by one request. Returns 1 and fills res when the
    // request yields a sample, 0 when the tone is finished (or has no samples at all).
    function automatic bit next_tone_sample(input bit rs, output t_tone_sample res);
        logic [63:0]         m, e64;
        logic [RATIO_W-1:0]  ratio;
        logic [SAMPLE_W-1:0] sine;
        bit                  neg;
        res = '0;
        if (rs) begin
            ph_acc  = '0;
            env_lvl = ENV_ONE;
            frm_cnt = '0;
            pk_mag  = '0;
            pk_idx  = '0;
        end
        if (frm_cnt >= count_reg)
            return 1'b0;

        sine = table_sine(ph_acc[PHASE_W-1 -: TABLE_W], neg);
        m = 64'(amp_reg) * 64'(sine);
        m = (m * 64'(env_lvl)) >> ENV_FRAC;
        m = m / 64'd32767;
        if (m > 64'd32767)
            m = 64'd32767;

        // An equal magnitude later on leaves the peak frame where it was.
        if (m > 64'(pk_mag)) begin
            pk_mag = m[SAMPLE_W-1:0];
            pk_idx = frm_cnt;
        end
        res.smp  = neg ? (16'd0 - m[SAMPLE_W-1:0]) : m[SAMPLE_W-1:0];
        res.frm  = frm_cnt;
        res.last = ((25'(frm_cnt) + 25'd1) == 25'(count_reg));
        res.pk   = pk_mag;
        res.pkf  = pk_idx;

        // A ratio above one is held at one, so the envelope stays put.
        ph_acc = ph_acc + step_reg;
        ratio  = (ratio_reg > ENV_ONE) ? ENV_ONE : ratio_reg;
        if (ratio != ENV_ONE) begin
            e64     = 64'(env_lvl) * 64'(ratio);
            env_lvl = RATIO_W'(e64 >> ENV_FRAC);
        end
        frm_cnt = frm_cnt + 1'b1;
        return 1'b1;
    endfunction

    // Register write on the plain write port; the predictor's copy follows it.
    task automatic cfg_write(input t_cfg_idx idx, input logic [WDATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:   step_reg  = val[STEP_REG_W-1:0];
            CFG_AMPLITUDE:    amp_reg   = val[AMP_REG_W-1:0];
            CFG_DECAY_RATIO:  ratio_reg = val[RATIO_W-1:0];
            CFG_SAMPLE_COUNT: count_reg = val[COUNT_REG_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Offers one request and holds it until the block takes it, then runs the
    // predictor on exactly that transfer.
    task automatic send_request(input bit rs, output bit has, output t_tone_sample got);
        i_in_valid <= 1'b1;
        i_restart  <= rs;
        do
            @(posedge i_clk);
        while (o_in_stall);
        has = next_tone_sample(rs, got);
        requests_sent++;
        if (rs)
            restarts_sent++;
    endtask

    // Gap after a request transfer: mostly none or short, now and then long.
    task automatic pause_sender(input bit gappy);
        int unsigned pick, gap;
        gap = 0;
        if (gappy) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                gap = $urandom_range(10, 40);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Brings the block to idle: every predicted sample has arrived, and a request
    // that gave nothing has had time to return to the accept step.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
    endtask

    // Checks every sample transfer against the oldest prediction, field by field.
    always @(posedge i_clk) begin : sample_check
        t_tone_sample seen, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_sample, o_frame, o_is_last, o_peak_value, o_peak_frame};
            samples_checked++;
            if (expected_samples.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected sample transfer, expected none, got 0x%0h",
                             $time, seen);
            end else begin
                want = expected_samples.pop_front();
                if (seen.smp !== want.smp)
                    report_field("sample", 32'(want.smp), 32'(seen.smp));
                if (seen.frm !== want.frm)
                    report_field("frame", 32'(want.frm), 32'(seen.frm));
                if (seen.last !== want.last)
                    report_field("is_last", 32'(want.last), 32'(seen.last));
                if (seen.pk !== want.pk)
                    report_field("peak_value", 32'(want.pk), 32'(seen.pk));
                if (seen.pkf !== want.pkf)
                    report_field("peak_frame", 32'(want.pkf), 32'(seen.pkf));
            end
        end
    end

    // Receiver side. A mode counter redraws the idling pattern between no stall,
    // short stalls and occasional long ones. Once enough samples have gone through,
    // the receiver holds off for a long stretch while the sender keeps offering, so
    // the result register fills and the block has to stall its request channel.
    initial begin : sample_receiver
        int unsigned burst, mode, mode_left, taken;
        bit          held;
        burst     = 0;
        mode      = 0;
        mode_left = 0;
        taken     = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                taken++;
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = 250;
            end else begin
                mode_left--;
            end
            if (!held && taken >= HOLD_AFTER) begin
                held  = 1'b1;
                burst = HOLD_CYCLES;
            end else if (burst == 0) begin
                case (mode)
                    1: if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, 3);
                    2: begin
                        if ($urandom_range(0, 11) == 0)
                            burst = $urandom_range(10, 40);
                        else if ($urandom_range(0, 4) == 0)
                            burst = $urandom_range(1, 2);
                    end
                    default: ;
                endcase
            end
            i_out_stall <= (burst != 0);
            if (burst != 0)
                burst--;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_tone_sample got;
        bit           has, dirty, gappy;
        int unsigned  phases, len, pick;
        logic [WDATA_W-1:0] val;

        // Directed script. After reset the sample count is zero, so nothing comes out.
        // With a quarter-turn phase step the table is hit at its zero crossings and
        // peaks, which gives 0, +full scale, 0, -full scale; the last of these equals
        // the peak and must not move the peak frame.
        script = '{
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b1, 1'b1, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b1, '0},
            '{1'b1, CFG_PHASE_STEP, 32'h4000_0000, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_SAMPLE_COUNT, 32'd4, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b1, 1'b0,
              {16'h0000, 24'd0, 1'b0, 16'h0000, 24'd0}},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b0,
              {16'h7FFF, 24'd1, 1'b0, 16'h7FFF, 24'd1}},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b0,
              {16'h0000, 24'd2, 1'b0, 16'h7FFF, 24'd1}},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b0,
              {16'h8001, 24'd3, 1'b1, 16'h7FFF, 24'd1}},
            // Tone finished: a plain request gives nothing.
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b1, '0},
            // Zero amplitude: silence, and the peak stays at zero.
            '{1'b1, CFG_AMPLITUDE, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b1, 1'b0,
              {16'h0000, 24'd0, 1'b0, 16'h0000, 24'd0}},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b0,
              {16'h0000, 24'd1, 1'b0, 16'h0000, 24'd0}},
            // Full amplitude with a zero decay ratio: the envelope dies after one sample.
            '{1'b1, CFG_AMPLITUDE, 32'h7FFF, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_DECAY_RATIO, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_PHASE_STEP, 32'h0400_0000, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_SAMPLE_COUNT, 32'd10, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            // Ratio above one is clamped, and the largest phase step runs backwards.
            '{1'b1, CFG_DECAY_RATIO, 32'h01FF_FFFF, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            // Sample count lowered below the current frame: output stops.
            '{1'b1, CFG_SAMPLE_COUNT, 32'd3, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b1, 1'b1, '0},
            // Restart with a sample count of zero clears the tone but gives nothing.
            '{1'b1, CFG_SAMPLE_COUNT, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b1, 1'b1, '0},
            // Largest sample count with a real decay at half amplitude.
            '{1'b1, CFG_SAMPLE_COUNT, 32'h00FF_FFFF, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_DECAY_RATIO, 32'h00FF_0000, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_AMPLITUDE, 32'h4000, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PHASE_STEP, 32'd0, 1'b0, 1'b0, 1'b0, '0}
        };

        dirty    = 1'b0;
        phases   = 0;

        // Reset is held at the start and then released for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].wr) begin
                if (dirty)
                    settle_block();
                dirty = 1'b0;
                cfg_write(script[i].idx, script[i].wdata);
            end else begin
                send_request(script[i].rs, has, got);
                dirty = 1'b1;
                if (script[i].typed) begin
                    if (!script[i].none)
                        expected_samples.push_back(script[i].want);
                end else if (has) begin
                    expected_samples.push_back(got);
                end
                pause_sender(1'b1);
            end
        end

        // Random tones. Each one starts from an idle block with a fresh mix of
        // register settings, most of them with a restart and run to their end plus a
        // request or two beyond it; a few skip the restart or restart half way.
        while (requests_sent < REQUEST_TARGET) begin
            settle_block();
            phases++;

            if ($urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       val = 32'd0;
                    1:       val = 32'hFFFF_FFFF;
                    2:       val = 32'h0040_0000;
                    3:       val = 32'h8000_0000;
                    default: val = $urandom();
                endcase
                cfg_write(CFG_PHASE_STEP, val);
            end
            if ($urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       val = 32'd0;
                    1:       val = 32'h7FFF;
                    2:       val = $urandom();
                    default: val = $urandom_range(0, 32767);
                endcase
                cfg_write(CFG_AMPLITUDE, val);
            end
            if ($urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       val = 32'(ENV_ONE);
                    1:       val = 32'd0;
                    2:       val = $urandom_range(32'h0100_0001, 32'h01FF_FFFF);
                    3:       val = $urandom();
                    default: val = $urandom_range(32'h00E0_0000, 32'h00FF_FFFF);
                endcase
                cfg_write(CFG_DECAY_RATIO, val);
            end
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       val = 32'd0;
                    1:       val = 32'h00FF_FFFF;
                    2:       val = 32'd1;
                    3:       val = $urandom();
                    default: val = $urandom_range(2, 40);
                endcase
                cfg_write(CFG_SAMPLE_COUNT, val);
            end

            // Long tones are only sampled for a while; short ones run past their end.
            if (count_reg == 0)
                len = $urandom_range(1, 3);
            else if (count_reg > 48)
                len = $urandom_range(16, 48);
            else
                len = 32'(count_reg) + $urandom_range(0, 2);
            gappy = ($urandom_range(0, 3) != 0);

            for (int unsigned n = 0; n < len; n++) begin
                if (n == 0)
                    send_request($urandom_range(0, 9) != 0, has, got);
                else
                    send_request($urandom_range(0, 39) == 0, has, got);
                if (has)
                    expected_samples.push_back(got);
                pause_sender(gappy);
            end
            dirty = 1'b1;
        end

        // Drain: every prediction must be met, then allow a little more time for any
        // stray transfer to show itself.
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            error_count++;
            $display("%0t: %0d predicted samples never arrived", $time,
                     expected_samples.size());
        end

        $display("Ran %0d requests (%0d with restart) over %0d random tones,", requests_sent,
                 restarts_sent, phases);
        $display("checked %0d sample transfers, made %0d register writes.", samples_checked,
                 reg_writes);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- decaying_sine_generator.f -----
src/dsg_pkg.sv
src/dsg_sine_rom.sv
src/decaying_sine_generator.sv
tb/tb_decaying_sine_generator.sv
